// ===== hw/rtl/x86a_pkg.sv =====
// ----------------------------------------------------------------------------
// x86a_pkg
// Shared types, operation codes and helpers for the 8086-style ALU.
// ----------------------------------------------------------------------------
package x86a_pkg;

    typedef enum logic {
        CMD_ARITH = 1'b0,
        CMD_SHIFT = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_OR  = 3'd1,
        ALU_ADC = 3'd2,
        ALU_SBB = 3'd3,
        ALU_AND = 3'd4,
        ALU_SUB = 3'd5,
        ALU_XOR = 3'd6,
        ALU_CMP = 3'd7
    } t_arith_func;

    typedef enum logic [2:0] {
        SH_ROL  = 3'd0,
        SH_ROR  = 3'd1,
        SH_RCL  = 3'd2,
        SH_RCR  = 3'd3,
        SH_SHL  = 3'd4,
        SH_SHR  = 3'd5,
        SH_NONE = 3'd6,
        SH_SAR  = 3'd7
    } t_shift_func;

    // Status flags, one bit each.
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } t_flags;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned COUNT_W = 8;

    // Clear the high byte in byte mode.
    function automatic logic [DATA_W-1:0] f_mask(input logic is_word,
                                                 input logic [DATA_W-1:0] v);
        f_mask = is_word ? v : {8'h00, v[7:0]};
    endfunction

    // Sign bit for the operand size.
    function automatic logic f_top(input logic is_word, input logic [DATA_W-1:0] v);
        f_top = is_word ? v[15] : v[7];
    endfunction

    // Even parity of the low byte.
    function automatic logic f_parity(input logic [DATA_W-1:0] v);
        f_parity = ~(^v[7:0]);
    endfunction

endpackage

// ===== hw/rtl/x86a_arith.sv =====
// ----------------------------------------------------------------------------
// x86a_arith
// Add/subtract/logic datapath with CF, AF, OF, PF, ZF and SF generation.
// ----------------------------------------------------------------------------
module x86a_arith (
    input  x86a_pkg::t_arith_func i_func,
    input  logic                  i_is_word,
    input  logic [15:0]           i_a,
    input  logic [15:0]           i_b,
    input  x86a_pkg::t_flags      i_flags,
    output logic [15:0]           o_result,
    output x86a_pkg::t_flags      o_flags
);
    import x86a_pkg::*;

    logic        w_cin;
    logic [16:0] w_sum;
    logic [16:0] w_diff;
    logic [4:0]  w_nib_sum;
    logic [4:0]  w_nib_diff;
    logic [15:0] w_add_res;
    logic [15:0] w_sub_res;
    logic [15:0] w_res;

    assign w_cin      = ((i_func == ALU_ADC) || (i_func == ALU_SBB)) ? i_flags.cf : 1'b0;
    assign w_sum      = {1'b0, i_a} + {1'b0, i_b} + {16'h0000, w_cin};
    // Operands are below 2^16, so bit 16 of the difference is the borrow.
    assign w_diff     = {1'b0, i_a} - {1'b0, i_b} - {16'h0000, w_cin};
    assign w_nib_sum  = {1'b0, i_a[3:0]} + {1'b0, i_b[3:0]} + {4'h0, w_cin};
    assign w_nib_diff = {1'b0, i_a[3:0]} - {1'b0, i_b[3:0]} - {4'h0, w_cin};
    assign w_add_res  = f_mask(i_is_word, w_sum[15:0]);
    assign w_sub_res  = f_mask(i_is_word, w_diff[15:0]);

    always_comb begin
        o_flags = i_flags;
        unique case (i_func)
            ALU_ADD, ALU_ADC: begin
                w_res      = w_add_res;
                o_flags.cf = i_is_word ? w_sum[16] : w_sum[8];
                o_flags.af = w_nib_sum[4];
                o_flags.of = f_top(i_is_word, ~(i_a ^ i_b) & (i_a ^ w_add_res));
            end
            ALU_SBB, ALU_SUB, ALU_CMP: begin
                w_res      = w_sub_res;
                o_flags.cf = w_diff[16];
                o_flags.af = w_nib_diff[4];
                o_flags.of = f_top(i_is_word, (i_a ^ i_b) & (i_a ^ w_sub_res));
            end
            ALU_OR, ALU_AND, ALU_XOR: begin
                if (i_func == ALU_OR) begin
                    w_res = i_a | i_b;
                end else if (i_func == ALU_AND) begin
                    w_res = i_a & i_b;
                end else begin
                    w_res = i_a ^ i_b;
                end
                o_flags.cf = 1'b0;
                o_flags.af = 1'b0;
                o_flags.of = 1'b0;
            end
            default: begin
                w_res = w_add_res;
            end
        endcase
        o_flags.pf = f_parity(w_res);
        o_flags.zf = (w_res == 16'h0000);
        o_flags.sf = f_top(i_is_word, w_res);
        // Compare keeps the first operand in the result field.
        o_result   = (i_func == ALU_CMP) ? i_a : w_res;
    end

endmodule

// ===== hw/rtl/x86a_shift.sv =====
// ----------------------------------------------------------------------------
// x86a_shift
// Barrel shifter for rotates, rotates through carry and shifts.
// ----------------------------------------------------------------------------
module x86a_shift (
    input  x86a_pkg::t_shift_func i_func,
    input  logic                  i_is_word,
    input  logic [15:0]           i_x,
    input  logic [7:0]            i_count,
    input  x86a_pkg::t_flags      i_flags,
    output logic [15:0]           o_result,
    output x86a_pkg::t_flags      o_flags
);
    import x86a_pkg::*;

    logic [3:0]         w_rot_cnt;
    logic [5:0]         w_t17;
    logic [4:0]         w_r17;
    logic [4:0]         w_t9;
    logic [3:0]         w_r9;
    logic [4:0]         w_rc_cnt;
    logic [31:0]        w_rolw;
    logic [15:0]        w_rolb;
    logic [31:0]        w_rorw;
    logic [15:0]        w_rorb;
    logic [33:0]        w_rclw;
    logic [17:0]        w_rclb;
    logic [33:0]        w_rcrw;
    logic [17:0]        w_rcrb;
    logic [16:0]        w_rc_v;
    logic [15:0]        w_rot_res;
    logic [16:0]        w_shlw;
    logic [8:0]         w_shlb;
    logic [16:0]        w_shrw;
    logic [8:0]         w_shrb;
    logic signed [16:0] w_sarw;
    logic signed [8:0]  w_sarb;
    logic [15:0]        w_res;
    logic               w_set_psz;
    logic               w_one;

    assign w_one     = (i_count == 8'd1);
    assign w_rot_cnt = i_is_word ? i_count[3:0] : {1'b0, i_count[2:0]};

    // count mod 17: 16 == -1 (mod 17), so low nibble minus high nibble.
    assign w_t17 = {2'b00, i_count[3:0]} - {2'b00, i_count[7:4]};
    assign w_r17 = w_t17[5] ? 5'(w_t17 + 6'd17) : w_t17[4:0];
    // count mod 9: 64 == 1 and 8 == -1 (mod 9).
    assign w_t9  = {3'b000, i_count[7:6]} + {2'b00, i_count[2:0]} - {2'b00, i_count[5:3]};
    always_comb begin
        if (w_t9[4]) begin
            w_r9 = 4'(w_t9 + 5'd9);
        end else if (w_t9 >= 5'd9) begin
            w_r9 = 4'(w_t9 - 5'd9);
        end else begin
            w_r9 = w_t9[3:0];
        end
    end
    assign w_rc_cnt = i_is_word ? w_r17 : {1'b0, w_r9};

    assign w_rolw = {i_x, i_x} << w_rot_cnt;
    assign w_rolb = {i_x[7:0], i_x[7:0]} << w_rot_cnt;
    assign w_rorw = {i_x, i_x} >> w_rot_cnt;
    assign w_rorb = {i_x[7:0], i_x[7:0]} >> w_rot_cnt;
    assign w_rclw = {i_flags.cf, i_x, i_flags.cf, i_x} << w_rc_cnt;
    assign w_rclb = {i_flags.cf, i_x[7:0], i_flags.cf, i_x[7:0]} << w_rc_cnt;
    assign w_rcrw = {i_flags.cf, i_x, i_flags.cf, i_x} >> w_rc_cnt;
    assign w_rcrb = {i_flags.cf, i_x[7:0], i_flags.cf, i_x[7:0]} >> w_rc_cnt;

    // Extra bit catches the last bit shifted out.
    assign w_shlw = {1'b0, i_x} << i_count;
    assign w_shlb = {1'b0, i_x[7:0]} << i_count;
    assign w_shrw = {i_x, 1'b0} >> i_count;
    assign w_shrb = {i_x[7:0], 1'b0} >> i_count;
    assign w_sarw = $signed({i_x, 1'b0}) >>> i_count;
    assign w_sarb = $signed({i_x[7:0], 1'b0}) >>> i_count;

    always_comb begin
        o_flags   = i_flags;
        w_res     = i_x;
        w_set_psz = 1'b0;
        w_rot_res = i_x;
        w_rc_v    = {i_flags.cf, i_x};
        if ((i_count != 8'd0) && (i_func != SH_NONE)) begin
            unique case (i_func)
                SH_ROL: begin
                    w_res      = i_is_word ? w_rolw[31:16] : {8'h00, w_rolb[15:8]};
                    o_flags.cf = w_res[0];
                    if (w_one) begin
                        o_flags.of = f_top(i_is_word, w_res) ^ w_res[0];
                    end
                end
                SH_ROR: begin
                    w_res      = i_is_word ? w_rorw[15:0] : {8'h00, w_rorb[7:0]};
                    o_flags.cf = f_top(i_is_word, w_res);
                    if (w_one) begin
                        o_flags.of = f_top(i_is_word, w_res)
                                   ^ (i_is_word ? w_res[14] : w_res[6]);
                    end
                end
                SH_RCL, SH_RCR: begin
                    if (i_func == SH_RCL) begin
                        w_rc_v = i_is_word ? w_rclw[33:17] : {8'h00, w_rclb[17:9]};
                    end else begin
                        w_rc_v = i_is_word ? w_rcrw[16:0] : {8'h00, w_rcrb[8:0]};
                    end
                    // Carry sits just above the operand.
                    w_rot_res = i_is_word ? w_rc_v[15:0] : {8'h00, w_rc_v[7:0]};
                    if (w_rc_cnt != 5'd0) begin
                        w_res      = w_rot_res;
                        o_flags.cf = i_is_word ? w_rc_v[16] : w_rc_v[8];
                        if (w_one) begin
                            if (i_func == SH_RCL) begin
                                o_flags.of = f_top(i_is_word, w_rot_res) ^ o_flags.cf;
                            end else begin
                                o_flags.of = f_top(i_is_word, i_x) ^ i_flags.cf;
                            end
                        end
                    end
                end
                SH_SHL: begin
                    w_set_psz  = 1'b1;
                    w_res      = i_is_word ? w_shlw[15:0] : {8'h00, w_shlb[7:0]};
                    o_flags.cf = i_is_word ? w_shlw[16] : w_shlb[8];
                    if (w_one) begin
                        o_flags.of = f_top(i_is_word, w_res) ^ o_flags.cf;
                    end
                end
                SH_SHR: begin
                    w_set_psz  = 1'b1;
                    w_res      = i_is_word ? w_shrw[16:1] : {8'h00, w_shrb[8:1]};
                    o_flags.cf = i_is_word ? w_shrw[0] : w_shrb[0];
                    if (w_one) begin
                        o_flags.of = f_top(i_is_word, i_x);
                    end
                end
                SH_SAR: begin
                    w_set_psz  = 1'b1;
                    w_res      = i_is_word ? w_sarw[16:1] : {8'h00, w_sarb[8:1]};
                    o_flags.cf = i_is_word ? w_sarw[0] : w_sarb[0];
                    if (w_one) begin
                        o_flags.of = 1'b0;
                    end
                end
                default: begin
                    w_res = i_x;
                end
            endcase
        end
        if (w_set_psz) begin
            o_flags.pf = f_parity(w_res);
            o_flags.zf = (w_res == 16'h0000);
            o_flags.sf = f_top(i_is_word, w_res);
        end
        o_result = w_res;
    end

endmodule

// ===== hw/rtl/x86_alu_with_flags_unit.sv =====
// ----------------------------------------------------------------------------
// x86_alu_with_flags_unit
// 8086-style 8/16-bit ALU and barrel shifter with persistent status flags.
// ----------------------------------------------------------------------------
// Each transaction runs one ALU or shift/rotate operation and returns one
// result carrying the six status flags as they stand afterwards. The flags
// live in one register that is updated as an operation leaves the input
// register, so the next operation sees them in the following cycle. A result
// moves from the input register to the result register and waits there while
// the output stalls. One operation is accepted every cycle unless a stalled
// result keeps the input register full; the two registers together let a new
// transaction enter while a finished result is still stalled.
// ----------------------------------------------------------------------------
module x86_alu_with_flags_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [2:0]  i_func,
    input  logic        i_is_word,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic [7:0]  i_shift_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_result,
    output logic        o_write_back,
    output logic        o_carry_out,
    output logic        o_parity_out,
    output logic        o_aux_out,
    output logic        o_zero_out,
    output logic        o_sign_out,
    output logic        o_overflow_out
);
    import x86a_pkg::*;

    logic        r_in_vld;
    logic        r_cmd;
    logic [2:0]  r_func;
    logic        r_is_word;
    logic [15:0] r_a;
    logic [15:0] r_b;
    logic [7:0]  r_cnt;
    logic        r_out_vld;
    logic [15:0] r_result;
    logic        r_write_back;
    t_flags      r_flags;

    logic        w_move;
    logic        w_accept;
    logic [15:0] w_a;
    logic [15:0] w_b;
    logic [15:0] w_arith_res;
    logic [15:0] w_shift_res;
    t_flags      w_arith_flags;
    t_flags      w_shift_flags;
    t_flags      n_flags;
    logic [15:0] n_result;
    logic        n_write_back;

    // Input stage hands its transaction to the result register.
    assign w_move     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_a = f_mask(r_is_word, r_a);
    assign w_b = f_mask(r_is_word, r_b);

    x86a_arith u_arith (
        .i_func    (t_arith_func'(r_func)),
        .i_is_word (r_is_word),
        .i_a       (w_a),
        .i_b       (w_b),
        .i_flags   (r_flags),
        .o_result  (w_arith_res),
        .o_flags   (w_arith_flags)
    );

    x86a_shift u_shift (
        .i_func    (t_shift_func'(r_func)),
        .i_is_word (r_is_word),
        .i_x       (w_a),
        .i_count   (r_cnt),
        .i_flags   (r_flags),
        .o_result  (w_shift_res),
        .o_flags   (w_shift_flags)
    );

    always_comb begin
        unique case (t_cmd'(r_cmd))
            CMD_ARITH: begin
                n_result     = w_arith_res;
                n_flags      = w_arith_flags;
                n_write_back = (t_arith_func'(r_func) != ALU_CMP);
            end
            CMD_SHIFT: begin
                n_result     = w_shift_res;
                n_flags      = w_shift_flags;
                n_write_back = 1'b1;
            end
            default: begin
                n_result     = w_shift_res;
                n_flags      = r_flags;
                n_write_back = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= '0;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_move) begin
                r_in_vld <= 1'b0;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
                r_flags   <= n_flags;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_cmd;
            r_func    <= i_func;
            r_is_word <= i_is_word;
            r_a       <= i_operand_a;
            r_b       <= i_operand_b;
            r_cnt     <= i_shift_count;
        end
        if (w_move) begin
            r_result     <= n_result;
            r_write_back <= n_write_back;
        end
    end

    // The flag register always holds the flags of the result on display.
    assign o_out_valid    = r_out_vld;
    assign o_result       = r_result;
    assign o_write_back   = r_write_back;
    assign o_carry_out    = r_flags.cf;
    assign o_parity_out   = r_flags.pf;
    assign o_aux_out      = r_flags.af;
    assign o_zero_out     = r_flags.zf;
    assign o_sign_out     = r_flags.sf;
    assign o_overflow_out = r_flags.of;

endmodule

// ===== hw/rtl/x86a_checker.sv =====
// ----------------------------------------------------------------------------
// x86a_checker
// Port-level checks for the ALU, bound to the top level.
// ----------------------------------------------------------------------------
module x86a_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_result,
    input logic        o_write_back,
    input logic        o_carry_out,
    input logic        o_parity_out,
    input logic        o_aux_out,
    input logic        o_zero_out,
    input logic        o_sign_out,
    input logic        o_overflow_out
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result)
            && $stable(o_write_back) && $stable(o_carry_out) && $stable(o_zero_out)
            && $stable(o_overflow_out))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted transaction did not reach the output");

    // A compare with equal operands leaves no borrow, aux borrow, overflow or sign, and sets parity.
    a_cmp_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_back && o_zero_out |-> !o_carry_out && !o_aux_out
            && !o_sign_out && !o_overflow_out && o_parity_out)
        else $error("inconsistent flags on equal compare");

endmodule

bind x86_alu_with_flags_unit x86a_checker u_x86a_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result       (o_result),
    .o_write_back   (o_write_back),
    .o_carry_out    (o_carry_out),
    .o_parity_out   (o_parity_out),
    .o_aux_out      (o_aux_out),
    .o_zero_out     (o_zero_out),
    .o_sign_out     (o_sign_out),
    .o_overflow_out (o_overflow_out)
);

// ===== dv/x86_alu_with_flags_unit_tb.sv =====
// ----------------------------------------------------------------------------
// x86_alu_with_flags_unit_tb
// Self-checking bench for the 8086-style ALU with persistent status flags.
// Directed corner operations, then random traffic under random input bursts
// and output back-pressure. A local flag-tracking predictor is compared
// field by field against every result transaction.
// ----------------------------------------------------------------------------
module x86_alu_with_flags_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import x86a_pkg::*;

    typedef struct {
        t_cmd        cmd;
        logic [2:0]  func;
        logic        is_word;
        logic [15:0] opa;
        logic [15:0] opb;
        logic [7:0]  count;
    } t_alu_op;

    typedef struct {
        logic [15:0] result;
        logic        write_back;
        t_flags      flags;
    } t_alu_res;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_cmd         = 1'b0;
    logic [2:0]  i_func        = '0;
    logic        i_is_word     = 1'b0;
    logic [15:0] i_operand_a   = '0;
    logic [15:0] i_operand_b   = '0;
    logic [7:0]  i_shift_count = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [15:0] o_result;
    logic        o_write_back;
    logic        o_carry_out;
    logic        o_parity_out;
    logic        o_aux_out;
    logic        o_zero_out;
    logic        o_sign_out;
    logic        o_overflow_out;

    t_flags      model_flags = '0;
    t_alu_res    pending_results[$];
    int          err_count   = 0;
    int          burst_left  = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          stall_run   = 0;
    int          stall_choices[4] = '{0, 25, 50, 85};

    x86_alu_with_flags_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_func         (i_func),
        .i_is_word      (i_is_word),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_shift_count  (i_shift_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result       (o_result),
        .o_write_back   (o_write_back),
        .o_carry_out    (o_carry_out),
        .o_parity_out   (o_parity_out),
        .o_aux_out      (o_aux_out),
        .o_zero_out     (o_zero_out),
        .o_sign_out     (o_sign_out),
        .o_overflow_out (o_overflow_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Flag-tracking predictor
    // ------------------------------------------------------------------------
    function automatic void update_psz(input int unsigned res, input int unsigned size);
        model_flags.pf = ~(^res[7:0]);
        model_flags.zf = (res == 0);
        model_flags.sf = 1'((res >> (size - 1)) & 1);
    endfunction

    function automatic t_alu_res predict_alu(input t_alu_op op);
        int unsigned size, mask, top, a, b, n, r, w, wmask, v, res, cin, sum, sgn, old_cf;
        t_alu_res    rsp;
        size  = op.is_word ? 16 : 8;
        mask  = (1 << size) - 1;
        top   = 1 << (size - 1);
        a     = op.opa & mask;
        b     = op.opb & mask;
        n     = 32'(op.count);
        res   = a;
        rsp.write_back = 1'b1;
        if (op.cmd == CMD_ARITH) begin
            cin = (op.func == ALU_ADC || op.func == ALU_SBB) ? 32'(model_flags.cf) : 0;
            case (t_arith_func'(op.func))
                ALU_ADD, ALU_ADC: begin
                    sum            = a + b + cin;
                    res            = sum & mask;
                    model_flags.cf = 1'((sum >> size) & 1);
                    model_flags.af = 1'((((a & 'hF) + (b & 'hF) + cin) >> 4) & 1);
                    model_flags.of = ((~(a ^ b)) & (a ^ res) & top) != 0;
                end
                ALU_SUB, ALU_SBB, ALU_CMP: begin
                    res            = (a - b - cin) & mask;
                    model_flags.cf = a < b + cin;
                    model_flags.af = (a & 'hF) < (b & 'hF) + cin;
                    model_flags.of = ((a ^ b) & (a ^ res) & top) != 0;
                end
                default: begin
                    if (op.func == ALU_OR) res = a | b;
                    else if (op.func == ALU_AND) res = a & b;
                    else res = a ^ b;
                    res            = res & mask;
                    model_flags.cf = 1'b0;
                    model_flags.of = 1'b0;
                    model_flags.af = 1'b0;
                end
            endcase
            update_psz(res, size);
            if (op.func == ALU_CMP) begin
                rsp.result     = 16'(a);
                rsp.write_back = 1'b0;
            end else begin
                rsp.result = 16'(res);
            end
        end else begin
            sgn    = (a >> (size - 1)) & 1;
            old_cf = 32'(model_flags.cf);
            // zero count and the empty function leave operand and flags alone
            if (n != 0 && op.func != SH_NONE) begin
                case (t_shift_func'(op.func))
                    SH_ROL, SH_ROR: begin
                        r = n % size;
                        if (r != 0) begin
                            if (op.func == SH_ROL)
                                res = ((a << r) | (a >> (size - r))) & mask;
                            else
                                res = ((a >> r) | (a << (size - r))) & mask;
                        end
                        if (op.func == SH_ROL) begin
                            model_flags.cf = 1'(res & 1);
                            if (n == 1)
                                model_flags.of = 1'(((res >> (size - 1)) ^ res) & 1);
                        end else begin
                            model_flags.cf = 1'((res >> (size - 1)) & 1);
                            if (n == 1)
                                model_flags.of =
                                    1'(((res >> (size - 1)) ^ (res >> (size - 2))) & 1);
                        end
                    end
                    SH_RCL, SH_RCR: begin
                        w     = size + 1;
                        wmask = (1 << w) - 1;
                        r     = n % w;
                        v     = (old_cf << size) | a;
                        if (r != 0) begin
                            if (op.func == SH_RCL) v = ((v << r) | (v >> (w - r))) & wmask;
                            else v = ((v >> r) | (v << (w - r))) & wmask;
                            res            = v & mask;
                            model_flags.cf = 1'((v >> size) & 1);
                            if (n == 1) begin
                                if (op.func == SH_RCL)
                                    model_flags.of = 1'(((res >> (size - 1)) ^ (v >> size)) & 1);
                                else
                                    model_flags.of = 1'(sgn ^ old_cf);
                            end
                        end
                    end
                    SH_SHL: begin
                        if (n <= size) begin
                            model_flags.cf = 1'((a >> (size - n)) & 1);
                            res = (n < size) ? ((a << n) & mask) : 0;
                        end else begin
                            model_flags.cf = 1'b0;
                            res = 0;
                        end
                        if (n == 1)
                            model_flags.of = 1'((res >> (size - 1)) & 1) ^ model_flags.cf;
                        update_psz(res, size);
                    end
                    SH_SHR: begin
                        if (n <= size) begin
                            model_flags.cf = 1'((a >> (n - 1)) & 1);
                            res = (n < size) ? (a >> n) : 0;
                        end else begin
                            model_flags.cf = 1'b0;
                            res = 0;
                        end
                        if (n == 1) model_flags.of = 1'(sgn);
                        update_psz(res, size);
                    end
                    default: begin
                        if (n < size) begin
                            model_flags.cf = 1'((a >> (n - 1)) & 1);
                            res = a >> n;
                            if (sgn != 0) res = res | (mask & ~(mask >> n));
                        end else begin
                            model_flags.cf = 1'(sgn);
                            res = (sgn != 0) ? mask : 0;
                        end
                        if (n == 1) model_flags.of = 1'b0;
                        update_psz(res, size);
                    end
                endcase
            end
            rsp.result = 16'(res);
        end
        rsp.flags = model_flags;
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic t_alu_op mk_op(input t_cmd c, input logic [2:0] f, input logic w,
                                      input logic [15:0] a, input logic [15:0] b,
                                      input logic [7:0] n);
        t_alu_op op;
        op.cmd     = c;
        op.func    = f;
        op.is_word = w;
        op.opa     = a;
        op.opb     = b;
        op.count   = n;
        return op;
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return 16'h007F;
            5:       return 16'h0080;
            6:       return 16'h00FF;
            7:       return 16'h000F;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Send one transaction; bursts of random length with optional idle gaps.
    task automatic send_op(input t_alu_op op);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            if ($urandom_range(99) < idle_pct) begin
                gap = $urandom_range(6, 1);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_cmd         <= op.cmd;
        i_func        <= op.func;
        i_is_word     <= op.is_word;
        i_operand_a   <= op.opa;
        i_operand_b   <= op.opb;
        i_shift_count <= op.count;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_alu(op));
    endtask

    task automatic test_arith_corners();
        idle_pct = 30;
        // byte mode ignores high bytes; wraps to zero with carry and aux carry
        send_op(mk_op(CMD_ARITH, ALU_ADD, 1'b0, 16'hAAFF, 16'h5501, 8'h00));
        send_op(mk_op(CMD_ARITH, ALU_ADC, 1'b1, 16'h7FFF, 16'h0000, 8'h00));
        send_op(mk_op(CMD_ARITH, ALU_ADD, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_op(mk_op(CMD_ARITH, ALU_SBB, 1'b0, 16'h0000, 16'h00FF, 8'h00));
        send_op(mk_op(CMD_ARITH, ALU_SUB, 1'b0, 16'h0080, 16'h0001, 8'h00));
        send_op(mk_op(CMD_ARITH, ALU_SUB, 1'b1, 16'h0000, 16'hFFFF, 8'h00));
        send_op(mk_op(CMD_ARITH, ALU_CMP, 1'b1, 16'h1234, 16'h1234, 8'h00));
        send_op(mk_op(CMD_ARITH, ALU_OR,  1'b0, 16'h000F, 16'h00F0, 8'h00));
        send_op(mk_op(CMD_ARITH, ALU_AND, 1'b1, 16'hFFFF, 16'h0000, 8'h00));
        send_op(mk_op(CMD_ARITH, ALU_XOR, 1'b1, 16'h8000, 16'h7FFF, 8'h00));
    endtask

    task automatic test_shift_corners();
        idle_pct = 30;
        send_op(mk_op(CMD_SHIFT, SH_ROL,  1'b0, 16'h0081, 16'hFFFF, 8'd0));
        send_op(mk_op(CMD_SHIFT, SH_NONE, 1'b1, 16'hC3A5, 16'h0000, 8'd5));
        send_op(mk_op(CMD_SHIFT, SH_ROL,  1'b0, 16'h0081, 16'h0000, 8'd1));
        send_op(mk_op(CMD_SHIFT, SH_ROR,  1'b1, 16'h0001, 16'h0000, 8'd1));
        // count is a multiple of the width: value kept, carry still updated
        send_op(mk_op(CMD_SHIFT, SH_ROL,  1'b1, 16'h8001, 16'h0000, 8'd16));
        send_op(mk_op(CMD_SHIFT, SH_RCL,  1'b0, 16'h0080, 16'h0000, 8'd9));
        send_op(mk_op(CMD_SHIFT, SH_RCL,  1'b0, 16'h0080, 16'h0000, 8'd1));
        send_op(mk_op(CMD_SHIFT, SH_RCR,  1'b1, 16'h8000, 16'h0000, 8'd1));
        send_op(mk_op(CMD_SHIFT, SH_RCR,  1'b1, 16'h1234, 16'h0000, 8'd17));
        send_op(mk_op(CMD_SHIFT, SH_SHL,  1'b0, 16'h00C0, 16'h0000, 8'd1));
        send_op(mk_op(CMD_SHIFT, SH_SHL,  1'b0, 16'h0001, 16'h0000, 8'd8));
        send_op(mk_op(CMD_SHIFT, SH_SHL,  1'b1, 16'hFFFF, 16'h0000, 8'd20));
        send_op(mk_op(CMD_SHIFT, SH_SHR,  1'b0, 16'h0081, 16'h0000, 8'd1));
        send_op(mk_op(CMD_SHIFT, SH_SAR,  1'b0, 16'h0080, 16'h0000, 8'd255));
        send_op(mk_op(CMD_SHIFT, SH_SAR,  1'b1, 16'h8001, 16'h0000, 8'd1));
    endtask

    task automatic test_random_traffic(input int num_ops);
        t_alu_op op;
        for (int i = 0; i < num_ops; i++) begin
            // alternate stretches of steady input with gappy input
            if (i % 100 == 0) idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 20);
            op.cmd     = t_cmd'($urandom_range(1));
            op.func    = 3'($urandom_range(7));
            op.is_word = 1'($urandom_range(1));
            op.opa     = pick_operand();
            op.opb     = pick_operand();
            op.count   = ($urandom_range(9) < 6) ? 8'($urandom_range(17))
                                                 : 8'($urandom_range(255));
            send_op(op);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output back-pressure: stall rate changes after each random-length run of cycles
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_run <= $urandom_range(120, 16);
            stall_pct <= stall_choices[$urandom_range(3)];
        end else begin
            stall_run <= stall_run - 1;
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_alu_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected result transaction, expected none actual %0h",
                         $time, o_result);
            end else begin
                want = pending_results.pop_front();
                check_field("result",     want.result,              o_result);
                check_field("write_back", 16'(want.write_back),     16'(o_write_back));
                check_field("CF",         16'(want.flags.cf),       16'(o_carry_out));
                check_field("PF",         16'(want.flags.pf),       16'(o_parity_out));
                check_field("AF",         16'(want.flags.af),       16'(o_aux_out));
                check_field("ZF",         16'(want.flags.zf),       16'(o_zero_out));
                check_field("SF",         16'(want.flags.sf),       16'(o_sign_out));
                check_field("OF",         16'(want.flags.of),       16'(o_overflow_out));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        model_flags = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_arith_corners();
        test_shift_corners();
        test_random_traffic(500);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // give any stray result time to show up
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
